/* hw/rtl/fpa_pkg.sv */
`timescale 1ns / 1ps
package fpa_pkg;

  // Fixed widths of the item fields
  localparam int unsigned FRAC_W     = 4;
  localparam int unsigned FRAC_MAX   = 15;
  localparam int unsigned RES_W      = 47;
  localparam int unsigned RFRAC_W    = 5;
  localparam int unsigned DIV_BITS_PER_STAGE = 4;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  // Sideband that travels with an item through the divider stages
  typedef struct packed {
    logic                is_div;
    logic                q_neg;
    logic                b_zero;
    logic [FRAC_W-1:0]   a_frac;
    logic [RES_W-1:0]    value;
    logic [RFRAC_W-1:0]  frac;
    status_e             status;
  } side_t;

endpackage

/* hw/rtl/fpa_div.sv */
`timescale 1ns / 1ps
module fpa_div import fpa_pkg::*; #(
  parameter int unsigned NUM_W = 31,
  parameter int unsigned DEN_W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  input  side_t                side_i,
  output logic                 valid_o,
  output logic [((NUM_W+DIV_BITS_PER_STAGE-1)/DIV_BITS_PER_STAGE)*DIV_BITS_PER_STAGE-1:0]
                               quo_o,
  output side_t                side_o
);

  localparam int unsigned BPS   = DIV_BITS_PER_STAGE;
  localparam int unsigned NSTG  = (NUM_W + BPS - 1) / BPS;
  localparam int unsigned PAD_W = NSTG * BPS;
  localparam int unsigned REM_W = DEN_W + 1;

  logic [NSTG:0]             v_q;
  logic [PAD_W-1:0]          acc_q [NSTG+1];
  logic [REM_W-1:0]          rem_q [NSTG+1];
  logic [DEN_W-1:0]          den_q [NSTG+1];
  side_t                     side_q [NSTG+1];

  // Stage zero is the input itself
  assign v_q[0]    = valid_i;
  assign acc_q[0]  = PAD_W'(num_i);
  assign rem_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar s = 1; s <= NSTG; s++) begin : g_stage
    logic [PAD_W-1:0] acc_d;
    logic [REM_W-1:0] rem_d;

    // Resolve BPS quotient bits by restoring steps
    always_comb begin
      acc_d = acc_q[s-1];
      rem_d = rem_q[s-1];
      for (int unsigned k = 0; k < BPS; k++) begin
        rem_d = {rem_d[DEN_W-1:0], acc_d[PAD_W-1]};
        acc_d = {acc_d[PAD_W-2:0], 1'b0};
        if (rem_d >= {1'b0, den_q[s-1]}) begin
          rem_d    = rem_d - {1'b0, den_q[s-1]};
          acc_d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_q[s-1];
      end
    end

    // Advance payload every cycle
    always_ff @(posedge clk_i) begin
      acc_q[s]  <= acc_d;
      rem_q[s]  <= rem_d;
      den_q[s]  <= den_q[s-1];
      side_q[s] <= side_q[s-1];
    end
  end

  assign valid_o = v_q[NSTG];
  assign quo_o   = acc_q[NSTG];
  assign side_o  = side_q[NSTG];

endmodule

/* hw/rtl/fixed_point_format_aligning_alu.sv */
`timescale 1ns / 1ps
// Channel   Handshake           Payload
// command   start_i / busy_o    mode_i a_value_i a_frac_i b_value_i b_frac_i
// result    done_o (strobe)     result_value_o result_frac_o status_o
//
// One command is taken every cycle; busy_o stays low.
// The result strobe follows the capture, align, sum/product and range-check
// registers, the pipelined restoring divider at 4 bits a stage and the final
// result register, on the same path for every operation.
// Add, subtract and multiply travel alongside the divider to keep order.
// Reset clears only the valid bits; the result strobe cannot be held off.
module fixed_point_format_aligning_alu import fpa_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      mode_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_value_i,
  input  logic [FRAC_W-1:0]               a_frac_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_value_i,
  input  logic [FRAC_W-1:0]               b_frac_i,
  output logic                            done_o,
  output logic signed [RES_W-1:0]         result_value_o,
  output logic [RFRAC_W-1:0]              result_frac_o,
  output logic [1:0]                      status_o
);

  localparam int unsigned OW    = OPERAND_WIDTH;
  localparam int unsigned SW    = OW + FRAC_MAX + 1;
  localparam int unsigned XW    = (SW > RES_W) ? SW : RES_W;
  localparam int unsigned PW    = 2 * OW;
  localparam int unsigned MW0   = PW + 2 * FRAC_MAX;
  localparam int unsigned MW    = (MW0 > RES_W + 1) ? MW0 : RES_W + 1;
  localparam int unsigned NUM_W = OW + FRAC_MAX;
  localparam int unsigned PAD_W =
    ((NUM_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE) * DIV_BITS_PER_STAGE;

  assign busy_o = 1'b0;

  // Stage 1: capture the command
  logic                   v1_q;
  mode_e                  mode1_q;
  logic signed [OW-1:0]   a1_q, b1_q;
  logic [FRAC_W-1:0]      fa1_q, fb1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mode1_q <= mode_e'(mode_i);
    a1_q    <= a_value_i;
    b1_q    <= b_value_i;
    fa1_q   <= a_frac_i;
    fb1_q   <= b_frac_i;
  end

  // Stage 2: align formats, take magnitudes
  logic [FRAC_W-1:0]    f2_d, da2_d, db2_d;
  logic signed [SW-1:0] ua2_d, ub2_d;
  logic [OW-1:0]        am2_d, bm2_d;
  logic [NUM_W-1:0]     num2_d;

  always_comb begin
    f2_d   = (fa1_q > fb1_q) ? fa1_q : fb1_q;
    da2_d  = f2_d - fa1_q;
    db2_d  = f2_d - fb1_q;
    ua2_d  = SW'(a1_q) <<< da2_d;
    ub2_d  = SW'(b1_q) <<< db2_d;
    am2_d  = a1_q[OW-1] ? OW'(-a1_q) : OW'(a1_q);
    bm2_d  = b1_q[OW-1] ? OW'(-b1_q) : OW'(b1_q);
    num2_d = NUM_W'(am2_d) << fb1_q;
  end

  logic                   v2_q;
  mode_e                  mode2_q;
  logic signed [SW-1:0]   ua2_q, ub2_q;
  logic [OW-1:0]          am2_q, bm2_q;
  logic [NUM_W-1:0]       num2_q;
  logic [FRAC_W-1:0]      f2_q, d2_q, fa2_q;
  logic [RFRAC_W-1:0]     sh2_q;
  logic                   neg2_q, bz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode2_q <= mode1_q;
    ua2_q   <= ua2_d;
    ub2_q   <= ub2_d;
    am2_q   <= am2_d;
    bm2_q   <= bm2_d;
    num2_q  <= num2_d;
    f2_q    <= f2_d;
    d2_q    <= da2_d | db2_d;
    fa2_q   <= fa1_q;
    sh2_q   <= RFRAC_W'(da2_d) + RFRAC_W'(db2_d);
    neg2_q  <= a1_q[OW-1] ^ b1_q[OW-1];
    bz2_q   <= (b1_q == '0);
  end

  // Stage 3: sum or difference, and magnitude product
  logic                   v3_q;
  mode_e                  mode3_q;
  logic signed [SW-1:0]   sum3_q;
  logic [PW-1:0]          prod3_q;
  logic [NUM_W-1:0]       num3_q;
  logic [OW-1:0]          bm3_q;
  logic [FRAC_W-1:0]      f3_q, d3_q, fa3_q;
  logic [RFRAC_W-1:0]     sh3_q;
  logic                   neg3_q, bz3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode3_q <= mode2_q;
    sum3_q  <= (mode2_q == MODE_SUB) ? ua2_q - ub2_q : ua2_q + ub2_q;
    prod3_q <= PW'(am2_q) * PW'(bm2_q);
    num3_q  <= num2_q;
    bm3_q   <= bm2_q;
    f3_q    <= f2_q;
    d3_q    <= d2_q;
    fa3_q   <= fa2_q;
    sh3_q   <= sh2_q;
    neg3_q  <= neg2_q;
    bz3_q   <= bz2_q;
  end

  // Stage 4: wrap the sum, scale the product, check ranges
  logic [FRAC_W:0]      wsh4_d;
  logic signed [SW-1:0] wr4_d;
  logic signed [XW-1:0] wx4_d;
  logic [MW-1:0]        p4_d, lim4_d, pn4_d;
  side_t                side4_d;

  always_comb begin
    wsh4_d = (FRAC_W+1)'(FRAC_MAX + 1) - (FRAC_W+1)'(d3_q);
    wr4_d  = (sum3_q <<< wsh4_d) >>> wsh4_d;
    wx4_d  = XW'(wr4_d);
    p4_d   = MW'(prod3_q) << sh3_q;
    lim4_d = (MW'(1) << (RES_W - 1)) - MW'(!neg3_q);
    pn4_d  = neg3_q ? MW'(-p4_d) : p4_d;

    side4_d        = '0;
    side4_d.is_div = (mode3_q == MODE_DIV);
    side4_d.q_neg  = neg3_q;
    side4_d.b_zero = bz3_q;
    side4_d.a_frac = fa3_q;
    side4_d.status = ST_OK;
    if (mode3_q == MODE_MUL) begin
      side4_d.value = pn4_d[RES_W-1:0];
      side4_d.frac  = RFRAC_W'({f3_q, 1'b0});
      if (p4_d > lim4_d) begin
        side4_d.status = ST_OVF;
      end
    end else begin
      side4_d.value = wx4_d[RES_W-1:0];
      side4_d.frac  = RFRAC_W'(f3_q);
      if (wr4_d != sum3_q) begin
        side4_d.status = ST_OVF;
      end
    end
  end

  logic              v4_q;
  side_t             side4_q;
  logic [NUM_W-1:0]  num4_q;
  logic [OW-1:0]     bm4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side4_q <= side4_d;
    num4_q  <= num3_q;
    bm4_q   <= bm3_q;
  end

  // Divider stages carry every item so results stay in order
  logic              vd;
  logic [PAD_W-1:0]  quo;
  side_t             sided;

  fpa_div #(
    .NUM_W (NUM_W),
    .DEN_W (OW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .num_i   (num4_q),
    .den_i   (bm4_q),
    .side_i  (side4_q),
    .valid_o (vd),
    .quo_o   (quo),
    .side_o  (sided)
  );

  // Final stage: sign and range of the quotient, pick the result
  logic [PAD_W-1:0]        qlim_d, qn_d;
  logic signed [OW-1:0]    qw_d;
  logic [RES_W-1:0]        val_d;
  logic [RFRAC_W-1:0]      frac_d;
  status_e                 st_d;

  always_comb begin
    qlim_d = (PAD_W'(1) << (OW - 1)) - PAD_W'(!sided.q_neg);
    qn_d   = sided.q_neg ? PAD_W'(-quo) : quo;
    qw_d   = qn_d[OW-1:0];
    val_d  = sided.value;
    frac_d = sided.frac;
    st_d   = sided.status;
    if (sided.is_div) begin
      frac_d = RFRAC_W'(sided.a_frac);
      if (sided.b_zero) begin
        val_d = '0;
        st_d  = ST_DIV0;
      end else begin
        val_d = RES_W'(qw_d);
        st_d  = (quo > qlim_d) ? ST_OVF : ST_OK;
      end
    end
  end

  logic               done_q;
  logic [RES_W-1:0]   val_q;
  logic [RFRAC_W-1:0] frac_q;
  status_e            st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    frac_q <= frac_d;
    st_q   <= st_d;
  end

  assign done_o         = done_q;
  assign result_value_o = val_q;
  assign result_frac_o  = frac_q;
  assign status_o       = st_q;

endmodule
